/* hw/rtl/ordered_list_engine_defines.svh */
// Assertion helpers for the ordered list engine.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Property that must hold in the same cycle.
`define OLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ole_pkg.sv */
package ole_pkg;

    localparam int MAX_LEN = 16;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 4;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 5;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 4'd0,
        CMD_LIST       = 4'd1,
        CMD_LENGTH     = 4'd2,
        CMD_INS_FRONT  = 4'd3,
        CMD_INS_AT     = 4'd4,
        CMD_DEL_FRONT  = 4'd5,
        CMD_DEL_END    = 4'd6,
        CMD_DEL_AT     = 4'd7,
        CMD_REVERSE    = 4'd8,
        CMD_SWAP       = 4'd9
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_EMPTY  = 3'd1,
        STAT_BADPOS = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_SHORT  = 3'd4
    } status_t;

    // What a cell loads on the next edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_HEAD
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LIST,
        ST_REV
    } ole_state_t;

endpackage

/* hw/rtl/ole_in_if.sv */
interface ole_in_if;
    import ole_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);

endinterface

/* hw/rtl/ole_out_if.sv */
interface ole_out_if;
    import ole_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element_value;
    logic [POS_W-1:0]         element_position;
    logic [LEN_W-1:0]         list_length;
    logic                     last;

    modport source (output valid, status, element_value, element_position, list_length, last,
                    input ready);
    modport sink   (input valid, status, element_value, element_position, list_length, last,
                    output ready);

endinterface

/* hw/rtl/ole_cell.sv */
module ole_cell (
    input  logic                              clk,
    input  ole_pkg::cell_op_t                 op,
    input  logic signed [ole_pkg::DATA_W-1:0] load_val,
    input  logic signed [ole_pkg::DATA_W-1:0] left_val,
    input  logic signed [ole_pkg::DATA_W-1:0] right_val,
    input  logic signed [ole_pkg::DATA_W-1:0] head_val,
    output logic signed [ole_pkg::DATA_W-1:0] val
);
    import ole_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;

    always_comb
    begin
        unique case (op)
            CELL_LOAD:  val_next = load_val;
            CELL_LEFT:  val_next = left_val;
            CELL_RIGHT: val_next = right_val;
            CELL_HEAD:  val_next = head_val;
            default:    val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* hw/rtl/ordered_list_engine.sv */
// Ordered list engine: keeps up to MAX_LEN (16) signed 32-bit values in order in a row of
// cells, each cell holding one element and able to take the value of its left or right
// neighbor, of the head cell, or of the incoming beat in any cycle. Commands arrive one beat
// at a time on req and each answers on rsp. Append, inserts, deletes, swap and length finish
// in the accept cycle: any element that moves shifts by one cell at once, and one status beat
// is returned. A listing returns one beat per stored element (one per cycle while rsp is
// ready), rotating the row left one cell per beat so the head cell always carries the next
// element; after count rotations the order is restored. Reverse returns its status beat at
// once and then works in the row, moving the head to the end of a shrinking prefix each
// cycle. A new command is taken only while no listing or reversal is running and the
// response register is free or being drained. Stored values are not cleared by reset; only
// elements below the count are ever read.
module ordered_list_engine (
    input  logic     clk,
    input  logic     rst_n,
    ole_in_if.sink   req,
    ole_out_if.source rsp
);
    import ole_pkg::*;

    `include "ordered_list_engine_defines.svh"

    ole_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         revm_reg, revm_next;

    logic                     ovld_reg, ovld_next;
    status_t                  ost_reg, ost_next;
    logic signed [DATA_W-1:0] oval_reg, oval_next;
    logic [POS_W-1:0]         opos_reg, opos_next;
    logic [LEN_W-1:0]         olen_reg, olen_next;
    logic                     olast_reg, olast_next;

    logic signed [DATA_W-1:0] cell_val [MAX_LEN];
    cell_op_t                 cell_op  [MAX_LEN];

    logic                     accept;
    logic                     out_free;
    cmd_t                     cmd;
    logic [CNT_W-1:0]         pos_c;
    logic [CNT_W-1:0]         pm1;
    logic                     full;
    logic                     pos_bad_ins;
    logic                     pos_bad_swap;
    logic [CNT_W-1:0]         list_pos;

    assign out_free  = !ovld_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign cmd       = cmd_t'(req.command);

    assign pos_c        = CNT_W'(req.position);
    assign pm1          = pos_c - 1'b1;
    assign full         = (cnt_reg == CNT_W'(MAX_LEN));
    assign pos_bad_ins  = (pos_c == '0) || (pos_c > cnt_reg);
    assign pos_bad_swap = (pos_c == '0) || (pos_c >= cnt_reg);
    assign list_pos     = CNT_W'(idx_reg) + 1'b1;

    // Row of cells; edge cells feed themselves where no neighbor exists.
    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_v;
        logic signed [DATA_W-1:0] right_v;

        if (g == 0)
        begin : g_first
            assign left_v = cell_val[0];
        end
        else
        begin : g_mid_l
            assign left_v = cell_val[g-1];
        end

        if (g == MAX_LEN - 1)
        begin : g_last
            assign right_v = cell_val[g];
        end
        else
        begin : g_mid_r
            assign right_v = cell_val[g+1];
        end

        ole_cell u_cell (
            .clk       (clk),
            .op        (cell_op[g]),
            .load_val  (req.value),
            .left_val  (left_v),
            .right_val (right_v),
            .head_val  (cell_val[0]),
            .val       (cell_val[g])
        );
    end

    always_comb
    begin
        logic             emit;
        status_t          st;
        logic [CNT_W-1:0] ci;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        revm_next  = revm_reg;
        ovld_next  = ovld_reg && !rsp.ready;
        ost_next   = ost_reg;
        oval_next  = oval_reg;
        opos_next  = opos_reg;
        olen_next  = olen_reg;
        olast_next = olast_reg;
        emit       = 1'b0;
        st         = STAT_OK;
        for (int i = 0; i < MAX_LEN; i++)
        begin
            cell_op[i] = CELL_HOLD;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    unique case (cmd)
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                st = STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_LEN; i++)
                                begin
                                    ci = CNT_W'(i);
                                    if (ci == cnt_reg) cell_op[i] = CELL_LOAD;
                                end
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_LIST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st = STAT_EMPTY;
                            end
                            else
                            begin
                                // beats come from the listing walk
                                emit       = 1'b0;
                                idx_next   = '0;
                                state_next = ST_LIST;
                            end
                        end
                        CMD_LENGTH:
                        begin
                            if (cnt_reg == '0) st = STAT_EMPTY;
                        end
                        CMD_INS_FRONT:
                        begin
                            if (full)
                            begin
                                st = STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_LEN; i++)
                                begin
                                    ci = CNT_W'(i);
                                    if (i == 0)             cell_op[i] = CELL_LOAD;
                                    else if (ci <= cnt_reg) cell_op[i] = CELL_LEFT;
                                end
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_INS_AT:
                        begin
                            if (pos_bad_ins)
                            begin
                                st = STAT_BADPOS;
                            end
                            else if (full)
                            begin
                                st = STAT_FULL;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_LEN; i++)
                                begin
                                    ci = CNT_W'(i);
                                    if (ci == pm1)                         cell_op[i] = CELL_LOAD;
                                    else if (ci > pm1 && ci <= cnt_reg)    cell_op[i] = CELL_LEFT;
                                end
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st = STAT_EMPTY;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_LEN; i++)
                                begin
                                    ci = CNT_W'(i);
                                    if ((ci + 1'b1) < cnt_reg) cell_op[i] = CELL_RIGHT;
                                end
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        CMD_DEL_END:
                        begin
                            if (cnt_reg == '0) st = STAT_EMPTY;
                            else               cnt_next = cnt_reg - 1'b1;
                        end
                        CMD_DEL_AT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st = STAT_EMPTY;
                            end
                            else if (pos_bad_ins)
                            begin
                                st = STAT_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_LEN; i++)
                                begin
                                    ci = CNT_W'(i);
                                    if (ci >= pm1 && (ci + 1'b1) < cnt_reg)
                                        cell_op[i] = CELL_RIGHT;
                                end
                                cnt_next = cnt_reg - 1'b1;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st = STAT_EMPTY;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                st = STAT_SHORT;
                            end
                            else
                            begin
                                revm_next  = IDX_W'(cnt_reg - 1'b1);
                                state_next = ST_REV;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st = STAT_EMPTY;
                            end
                            else if (pos_bad_swap)
                            begin
                                st = STAT_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < MAX_LEN; i++)
                                begin
                                    ci = CNT_W'(i);
                                    if (ci == pm1)        cell_op[i] = CELL_RIGHT;
                                    else if (ci == pos_c) cell_op[i] = CELL_LEFT;
                                end
                            end
                        end
                        default: ;  // unused codes: report ok and the length
                    endcase

                    if (emit)
                    begin
                        ovld_next  = 1'b1;
                        ost_next   = st;
                        oval_next  = '0;
                        opos_next  = '0;
                        olen_next  = LEN_W'(cnt_next);
                        olast_next = 1'b1;
                    end
                end
            end

            ST_LIST:
            begin
                if (out_free)
                begin
                    // Send the head element and rotate the stored run left by one.
                    ovld_next  = 1'b1;
                    ost_next   = STAT_OK;
                    oval_next  = cell_val[0];
                    opos_next  = POS_W'(list_pos);
                    olen_next  = LEN_W'(cnt_reg);
                    olast_next = (list_pos == cnt_reg);
                    for (int i = 0; i < MAX_LEN; i++)
                    begin
                        ci = CNT_W'(i);
                        if ((ci + 1'b1) < cnt_reg)       cell_op[i] = CELL_RIGHT;
                        else if ((ci + 1'b1) == cnt_reg) cell_op[i] = CELL_HEAD;
                    end
                    if (list_pos == cnt_reg)
                    begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_REV:
            begin
                // Move the head to the end of the prefix, then shrink the prefix.
                for (int i = 0; i < MAX_LEN; i++)
                begin
                    ci = CNT_W'(i);
                    if (ci < CNT_W'(revm_reg))       cell_op[i] = CELL_RIGHT;
                    else if (ci == CNT_W'(revm_reg)) cell_op[i] = CELL_HEAD;
                end
                revm_next = revm_reg - 1'b1;
                if (revm_reg == IDX_W'(1)) state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            revm_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            revm_reg  <= revm_next;
            ovld_reg  <= ovld_next;
        end
    end

    // Response payload: no reset needed, qualified by ovld_reg.
    always_ff @(posedge clk)
    begin
        ost_reg   <= ost_next;
        oval_reg  <= oval_next;
        opos_reg  <= opos_next;
        olen_reg  <= olen_next;
        olast_reg <= olast_next;
    end

    assign rsp.valid            = ovld_reg;
    assign rsp.status           = ost_reg;
    assign rsp.element_value    = oval_reg;
    assign rsp.element_position = opos_reg;
    assign rsp.list_length      = olen_reg;
    assign rsp.last             = olast_reg;

    `OLE_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_LEN), "element count above capacity")
    `OLE_ASSERT_NEXT(a_cnt_only_on_cmd, !accept, $stable(cnt_reg), "count moved without a command")
    `OLE_ASSERT(a_rev_prefix, (state_reg != ST_REV) || (revm_reg != '0), "reverse prefix ran empty")
    `OLE_ASSERT(a_list_idx, (state_reg != ST_LIST) || (CNT_W'(idx_reg) < cnt_reg), "listing index past count")

endmodule
